>>> hdl/itora_pkg.sv
// Package with the types, constants and helpers shared by the radix ASCII converter.
`default_nettype none

package itora_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned MAX_DIGITS_DEF = 64;

  localparam logic [5:0] RADIX_MIN    = 6'd2;
  localparam logic [5:0] RADIX_MAX    = 6'd36;
  localparam logic [5:0] SIGNED_RADIX = 6'd10;
  localparam logic [5:0] DEC_DIGITS   = 6'd10;

  localparam logic       FUNC_SIGNED   = 1'b0;
  localparam logic       FUNC_UNSIGNED = 1'b1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  typedef struct packed {
    logic        func;
    logic [63:0] value;
    logic [5:0]  radix;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
    logic       error;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_SIGN,
    ST_READ,
    ST_LOAD,
    ST_ERR
  } state_e;

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + {2'b00, d};
    end else begin
      c = CHAR_A + {2'b00, d} - {2'b00, DEC_DIGITS};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/itora_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module itora_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/integer_to_radix_ascii_core.sv
// Top level of the integer to radix ASCII converter.
// The block takes one value at a time and turns it into ASCII digits, most
// significant first, with last set on the final character. Each digit comes
// from a shift-subtract divider that produces one quotient bit per cycle, and
// the digits are kept in a small RAM and then read back through its registered
// read port, one character at a time, with a minus sign going first. A bad radix
// puts its single error result in the output register from the error state
// once the output slot is free. The next value is taken as soon as the final
// character sits in the output register.
`default_nettype none

module integer_to_radix_ascii_core #(
  parameter int unsigned VALUE_BITS = itora_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = itora_pkg::MAX_DIGITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire itora_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output itora_pkg::out_t      out_data_o
);

  import itora_pkg::*;

  localparam int unsigned BW = $clog2(VALUE_BITS);
  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [5:0]            rem_q, rem_d;
  logic [5:0]            radix_q, radix_d;
  logic [BW-1:0]         bit_q, bit_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic                  in_fire;
  logic                  radix_ok;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] val_in;
  logic                  slot_free;
  logic                  more_digits;
  logic [6:0]            shifted;
  logic [6:0]            diff;
  logic                  qbit;

  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [5:0]            ram_rdata;
  logic                  load_sign;
  logic                  load_digit;
  logic                  load_err;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign radix_ok  = (in_data_i.radix >= RADIX_MIN) && (in_data_i.radix <= RADIX_MAX);
  assign neg_in    = (in_data_i.func == FUNC_SIGNED) && (in_data_i.radix == SIGNED_RADIX)
                     && in_data_i.value[VALUE_BITS-1];
  assign val_in    = neg_in ? (~in_data_i.value[VALUE_BITS-1:0] + VALUE_BITS'(1))
                            : in_data_i.value[VALUE_BITS-1:0];
  assign slot_free = !out_valid_q || !out_stall_i;

  assign shifted     = {rem_q, val_q[VALUE_BITS-1]};
  assign diff        = shifted - {1'b0, radix_q};
  assign qbit        = shifted >= {1'b0, radix_q};
  assign more_digits = (val_q != '0) && (cnt_q < CW'(MAX_DIGITS - 1));

  assign ram_waddr = cnt_q[AW-1:0];
  assign ram_raddr = AW'(cnt_q - CW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = radix_ok ? ST_DIV : ST_ERR;
        end
      end
      ST_DIV: begin
        if (bit_q == BW'(VALUE_BITS - 1)) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (more_digits) begin
          state_d = ST_DIV;
        end else if (neg_q) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          state_d = (cnt_q == CW'(1)) ? ST_IDLE : ST_READ;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    load_err   = 1'b0;
    case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_DIGIT: ram_we     = 1'b1;
      ST_SIGN:  load_sign  = slot_free;
      ST_READ:  ram_re     = 1'b1;
      ST_LOAD:  load_digit = slot_free;
      ST_ERR:   load_err   = slot_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    val_d   = val_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    bit_d   = bit_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    if (in_fire) begin
      val_d   = val_in;
      rem_d   = '0;
      radix_d = in_data_i.radix;
      bit_d   = '0;
      cnt_d   = '0;
      neg_d   = neg_in;
    end
    if (state_q == ST_DIV) begin
      val_d = {val_q[VALUE_BITS-2:0], qbit};
      rem_d = qbit ? diff[5:0] : shifted[5:0];
      bit_d = bit_q + BW'(1);
    end
    if (state_q == ST_DIGIT) begin
      cnt_d = cnt_q + CW'(1);
      rem_d = '0;
      bit_d = '0;
    end
    if (load_digit) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_sign) begin
      out_valid_d = 1'b1;
      out_d       = '{char_code: CHAR_MINUS, last: 1'b0, error: 1'b0};
    end else if (load_digit) begin
      out_valid_d = 1'b1;
      out_d       = '{char_code: digit_char(ram_rdata), last: (cnt_q == CW'(1)),
                      error: 1'b0};
    end else if (load_err) begin
      out_valid_d = 1'b1;
      out_d       = '{char_code: CHAR_NONE, last: 1'b1, error: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    out_q   <= out_d;
  end

  itora_ram #(
    .WIDTH (6),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rem_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("Input taken again right after a transfer.");

  a_write_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (in_stall_o && (cnt_q < CW'(MAX_DIGITS))))
    else $error("Digit RAM written while idle or beyond its depth.");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |-> (out_data_o.last && (out_data_o.char_code == CHAR_NONE)))
    else $error("Error result without last or with a character.");

  a_digit_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (rem_q < radix_q))
    else $error("Digit remainder not below the radix.");
`endif

endmodule

`default_nettype wire

>>> tb/integer_to_radix_ascii_core_test.sv
// Self-checking testbench for the integer to radix ASCII converter core.
`timescale 1ns / 100ps

module integer_to_radix_ascii_core_test;
  import itora_pkg::*;

  localparam int RANDOM_ITEMS = 126;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  out_t pending_chars[$];
  int   mismatch_cnt = 0;
  out_t want;

  in_t   plan_item[$];
  bit    plan_bad[$];
  string plan_text[$];

  integer_to_radix_ascii_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic expand_digits(input in_t item);
    logic [63:0] mag;
    logic [63:0] rem;
    logic [63:0] base;
    logic [7:0]  digs[64];
    int          n;
    bit          neg;
    if (item.radix < RADIX_MIN || item.radix > RADIX_MAX) begin
      pending_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
      return;
    end
    base = {58'd0, item.radix};
    mag  = item.value;
    neg  = (item.func == FUNC_SIGNED) && (item.radix == SIGNED_RADIX) && mag[63];
    if (neg) begin
      mag = -mag;
    end
    n = 0;
    do begin
      rem = mag % base;
      digs[n] = (rem < 10) ? CHAR_ZERO + rem[7:0] : CHAR_A + rem[7:0] - 8'd10;
      mag = mag / base;
      n++;
    end while (mag != 0 && n < 64);
    if (neg) begin
      pending_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      pending_chars.push_back('{digs[i], i == 0, 1'b0});
    end
  endtask

  task automatic expect_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back('{8'(s[i]), i == s.len() - 1, 1'b0});
    end
  endtask

  task automatic add_row(input logic f, input logic [63:0] v, input logic [5:0] r,
                         input bit bad, input string text);
    in_t item;
    item.func  = f;
    item.value = v;
    item.radix = r;
    plan_item.push_back(item);
    plan_bad.push_back(bad);
    plan_text.push_back(text);
  endtask

  function automatic in_t random_item();
    in_t         item;
    logic [63:0] raw;
    int          width;
    int          roll;
    raw   = {$urandom, $urandom};
    width = $urandom_range(1, 64);
    roll  = $urandom_range(0, 99);
    item.func = 1'($urandom_range(0, 1));
    if (roll < 10) begin
      item.radix = $urandom_range(0, 1) ? 6'($urandom_range(0, 1)) : 6'($urandom_range(37, 63));
    end else if (roll < 45) begin
      item.radix = SIGNED_RADIX;
    end else begin
      item.radix = 6'($urandom_range(2, 36));
    end
    if (width < 64) begin
      raw = raw >> (64 - width);
    end
    if ($urandom_range(0, 3) == 0) begin
      raw = -raw;
    end
    item.value = raw;
    return item;
  endfunction

  task automatic transfer(input in_t item);
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, out_data_o);
        mismatch_cnt++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data_o.char_code !== want.char_code) begin
          $display("%0t: char_code expected %h actual %h", $time, want.char_code,
                   out_data_o.char_code);
          mismatch_cnt++;
        end
        if (out_data_o.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_data_o.last);
          mismatch_cnt++;
        end
        if (out_data_o.error !== want.error) begin
          $display("%0t: error expected %b actual %b", $time, want.error, out_data_o.error);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      n = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      out_stall_i <= 1'b0;
      repeat (n) @(posedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_t item;
    bit  burst;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    burst      = 1'b0;

    add_row(FUNC_SIGNED,   64'd0,                  6'd10, 1'b0, "0");
    add_row(FUNC_UNSIGNED, 64'd0,                  6'd2,  1'b0, "0");
    add_row(FUNC_UNSIGNED, 64'hffff_ffff_ffff_ffff, 6'd16, 1'b0, "ffffffffffffffff");
    add_row(FUNC_UNSIGNED, 64'hffff_ffff_ffff_ffff, 6'd2,  1'b0, "");
    add_row(FUNC_SIGNED,   64'h8000_0000_0000_0000, 6'd10, 1'b0, "-9223372036854775808");
    add_row(FUNC_SIGNED,   64'hffff_ffff_ffff_ffff, 6'd10, 1'b0, "-1");
    add_row(FUNC_SIGNED,   64'h7fff_ffff_ffff_ffff, 6'd10, 1'b0, "9223372036854775807");
    add_row(FUNC_UNSIGNED, 64'hffff_ffff_ffff_ffff, 6'd10, 1'b0, "18446744073709551615");
    add_row(FUNC_SIGNED,   64'hffff_ffff_ffff_ffff, 6'd16, 1'b0, "ffffffffffffffff");
    add_row(FUNC_UNSIGNED, 64'd35,                 6'd36, 1'b0, "z");
    add_row(FUNC_UNSIGNED, 64'd36,                 6'd36, 1'b0, "10");
    add_row(FUNC_UNSIGNED, 64'hffff_ffff_ffff_ffff, 6'd36, 1'b0, "");
    add_row(FUNC_SIGNED,   64'd5,                  6'd0,  1'b1, "");
    add_row(FUNC_UNSIGNED, 64'hffff_ffff_ffff_ffff, 6'd1,  1'b1, "");
    add_row(FUNC_SIGNED,   64'h8000_0000_0000_0000, 6'd37, 1'b1, "");
    add_row(FUNC_UNSIGNED, 64'd12345,              6'd63, 1'b1, "");
    add_row(FUNC_SIGNED,   64'd9,                  6'd10, 1'b0, "9");
    add_row(FUNC_SIGNED,   64'd10,                 6'd10, 1'b0, "10");
    add_row(FUNC_SIGNED,   -64'd10,                6'd10, 1'b0, "-10");
    add_row(FUNC_UNSIGNED, 64'd255,                6'd3,  1'b0, "");
    add_row(FUNC_UNSIGNED, 64'haaaa_aaaa_aaaa_aaaa, 6'd2,  1'b0, "");
    add_row(FUNC_SIGNED,   64'h5555_5555_5555_5555, 6'd8,  1'b0, "");
    add_row(FUNC_SIGNED,   64'hffff_ffff_ffff_ffff, 6'd2,  1'b0, "");
    add_row(FUNC_UNSIGNED, 64'h0123_4567_89ab_cdef, 6'd35, 1'b0, "");

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < plan_item.size(); i++) begin
      transfer(plan_item[i]);
      if (plan_bad[i]) begin
        pending_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
      end else if (plan_text[i].len() != 0) begin
        expect_text(plan_text[i]);
      end else begin
        expand_digits(plan_item[i]);
      end
      pause_sender(pick_gap());
    end

    // The sender holds off until the directed results have all come back.
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      if (i % 40 == 39) begin
        drain();
      end
      item = random_item();
      transfer(item);
      expand_digits(item);
      pause_sender(burst ? 0 : pick_gap());
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
